>>> rtl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg: shared types and constants of the steering update block
// Payload widths, configuration layout, job record and queue sizing.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int W        = 32;   // position, velocity, acceleration fields
  localparam int CW       = 31;   // configuration register width
  localparam int TSW      = 16;   // time step width, Q0.16
  localparam int SEPW     = 40;   // separation sum width
  localparam int VW       = 42;   // working width of a vector component
  localparam int PW       = 62;   // 31x31 product width
  localparam int SQW      = 63;   // sum of two squares
  localparam int RW       = 32;   // root width
  localparam int CFG_AW   = 3;    // register index width
  localparam int Q_DEPTH  = 2;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int GAIN_SH3 = 3;    // arrive gain of ten as (d << 3) + (d << 1)
  localparam int GAIN_SH1 = 1;
  localparam int DT_SH    = 16;   // time step fraction bits

  // register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_MAX_ACCEL    = 3'd0,
    REG_MAX_SPEED    = 3'd1,
    REG_TIME_STEP    = 3'd2,
    REG_WORLD_WIDTH  = 3'd3,
    REG_WORLD_HEIGHT = 3'd4,
    REG_ARRIVE_RAD   = 3'd5,
    REG_SLOW_RAD     = 3'd6,
    REG_SEP_DIST     = 3'd7
  } sas_reg_t;

  localparam logic [CW-1:0]  RST_MAX_ACCEL    = 31'd6553600;
  localparam logic [CW-1:0]  RST_MAX_SPEED    = 31'd13107200;
  localparam logic [TSW-1:0] RST_TIME_STEP    = 16'd1092;
  localparam logic [CW-1:0]  RST_WORLD_WIDTH  = 31'd67108864;
  localparam logic [CW-1:0]  RST_WORLD_HEIGHT = 31'd50331648;
  localparam logic [CW-1:0]  RST_ARRIVE_RAD   = 31'd327680;
  localparam logic [CW-1:0]  RST_SLOW_RAD     = 31'd1966080;
  localparam logic [CW-1:0]  RST_SEP_DIST     = 31'd1310720;

  // opcodes
  localparam logic OP_NEIGHBOR = 1'b0;
  localparam logic OP_UPDATE   = 1'b1;

  typedef struct packed {
    logic [CW-1:0]  max_accel;
    logic [CW-1:0]  max_speed;
    logic [TSW-1:0] time_step;
    logic [CW-1:0]  world_width;
    logic [CW-1:0]  world_height;
    logic [CW-1:0]  arrive_radius;
    logic [CW-1:0]  slow_radius;
    logic [CW-1:0]  separate_distance;
  } sas_cfg_t;

  // classified request: difference vector already formed
  typedef struct packed {
    logic                opcode;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
  } sas_job_t;

  // queue handshake between front and back
  typedef struct packed {
    logic push;
    logic pop;
  } sas_qctl_t;

  typedef struct packed {
    logic full;
    logic avail;
  } sas_qsts_t;

endpackage

>>> rtl/sas_in_if.sv
// ----------------------------------------------------------------------------
// sas_in_if: request channel of the steering update block
// Valid/ready handshake with the agent and neighbor fields.
// ----------------------------------------------------------------------------
interface sas_in_if;
  import sas_pkg::*;

  logic                valid;
  logic                ready;
  logic                opcode;
  logic signed [W-1:0] other_x;
  logic signed [W-1:0] other_y;
  logic signed [W-1:0] pos_x;
  logic signed [W-1:0] pos_y;
  logic signed [W-1:0] vel_x;
  logic signed [W-1:0] vel_y;
  logic signed [W-1:0] acc_x;
  logic signed [W-1:0] acc_y;
  logic signed [W-1:0] goal_x;
  logic signed [W-1:0] goal_y;

  modport source (output valid, opcode, other_x, other_y, pos_x, pos_y, vel_x, vel_y,
                  acc_x, acc_y, goal_x, goal_y, input ready);
  modport sink   (input valid, opcode, other_x, other_y, pos_x, pos_y, vel_x, vel_y,
                  acc_x, acc_y, goal_x, goal_y, output ready);
endinterface

>>> rtl/sas_out_if.sv
// ----------------------------------------------------------------------------
// sas_out_if: result channel of the steering update block
// Valid/ready handshake with the new agent state.
// ----------------------------------------------------------------------------
interface sas_out_if;
  import sas_pkg::*;

  logic                valid;
  logic                ready;
  logic signed [W-1:0] new_pos_x;
  logic signed [W-1:0] new_pos_y;
  logic signed [W-1:0] new_vel_x;
  logic signed [W-1:0] new_vel_y;
  logic signed [W-1:0] new_acc_x;
  logic signed [W-1:0] new_acc_y;

  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                  new_acc_x, new_acc_y, input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                  new_acc_x, new_acc_y, output ready);
endinterface

>>> rtl/sas_front.sv
// ----------------------------------------------------------------------------
// sas_front: request intake
// Accepts requests while the queue has room and forms the saturated
// difference vector (self minus neighbor, or goal minus self).
// ----------------------------------------------------------------------------
module sas_front (
  sas_in_if.sink               in_ch,
  input  sas_pkg::sas_qsts_t   q_sts,
  output logic                 push,
  output sas_pkg::sas_job_t    job
);
  import sas_pkg::*;

  function automatic logic signed [W-1:0] sat_diff(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] d;
    d = (W+1)'(a) - (W+1)'(b);
    if (d > $signed({2'b00, {(W-1){1'b1}}}))
      return $signed({1'b0, {(W-1){1'b1}}});
    else if (d < -$signed({2'b00, {(W-1){1'b1}}}))
      return -$signed({1'b0, {(W-1){1'b1}}});
    else
      return d[W-1:0];
  endfunction

  assign in_ch.ready = !q_sts.full;
  assign push        = in_ch.valid && !q_sts.full;

  // classify and form the difference vector
  always_comb begin
    job.opcode = in_ch.opcode;
    if (in_ch.opcode == OP_NEIGHBOR) begin
      job.dx = sat_diff(in_ch.pos_x, in_ch.other_x);
      job.dy = sat_diff(in_ch.pos_y, in_ch.other_y);
    end else begin
      job.dx = sat_diff(in_ch.goal_x, in_ch.pos_x);
      job.dy = sat_diff(in_ch.goal_y, in_ch.pos_y);
    end
    job.px = in_ch.pos_x;
    job.py = in_ch.pos_y;
    job.vx = in_ch.vel_x;
    job.vy = in_ch.vel_y;
    job.ax = in_ch.acc_x;
    job.ay = in_ch.acc_y;
  end

endmodule

>>> rtl/sas_fifo.sv
// ----------------------------------------------------------------------------
// sas_fifo: short request queue between front and back
// Flip-flop queue of classified requests.
// ----------------------------------------------------------------------------
module sas_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  sas_pkg::sas_qctl_t  q_ctl,
  input  sas_pkg::sas_job_t   din,
  output sas_pkg::sas_qsts_t  q_sts,
  output sas_pkg::sas_job_t   dout
);
  import sas_pkg::*;

  sas_job_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r;
  logic [Q_AW-1:0] rp_r;
  logic [Q_AW:0]   cnt_r;

  assign q_sts.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign q_sts.avail = (cnt_r != '0);
  assign dout        = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (q_ctl.push) wp_r <= (wp_r == Q_AW'(Q_DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (q_ctl.pop)  rp_r <= (rp_r == Q_AW'(Q_DEPTH-1)) ? '0 : rp_r + 1'b1;
      if (q_ctl.push && !q_ctl.pop)      cnt_r <= cnt_r + 1'b1;
      else if (!q_ctl.push && q_ctl.pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (q_ctl.push) mem_r[wp_r] <= din;
  end

endmodule

>>> rtl/sas_isqrt.sv
// ----------------------------------------------------------------------------
// sas_isqrt: iterative integer square root
// Floor root of a 63-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module sas_isqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [sas_pkg::SQW-1:0] din,
  output logic                   done,
  output logic [sas_pkg::RW-1:0]  root
);
  import sas_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [63:0] op_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;
  assign done  = done_r;
  assign root  = res_r[RW-1:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // digit recurrence
  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= 64'(din);
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (op_r >= trial) begin
        op_r  <= op_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

>>> rtl/sas_div.sv
// ----------------------------------------------------------------------------
// sas_div: iterative unsigned divider
// 62-bit by 32-bit restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sas_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [sas_pkg::PW-1:0]  dvd,
  input  logic [sas_pkg::RW-1:0]  dvs,
  output logic                    done,
  output logic [sas_pkg::PW-1:0]  quo
);
  import sas_pkg::*;

  localparam int CNT_W = $clog2(PW);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PW-1:0]    q_r;
  logic [RW-1:0]    rem_r;
  logic [RW-1:0]    dvs_r;
  logic [RW:0]      shifted;
  logic             take;

  assign shifted = {rem_r, q_r[PW-1]};
  assign take    = (shifted >= {1'b0, dvs_r});
  assign done    = done_r;
  assign quo     = q_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PW-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-subtract step
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dvd;
      rem_r <= '0;
      dvs_r <= dvs;
    end else if (busy_r) begin
      rem_r <= take ? RW'(shifted - {1'b0, dvs_r}) : shifted[RW-1:0];
      q_r   <= {q_r[PW-2:0], take};
    end
  end

endmodule

>>> rtl/sas_back.sv
// ----------------------------------------------------------------------------
// sas_back: steering sequencer
// Runs separation accumulation and the arrive/integrate update on a shared
// multiplier, square root unit and divider, and holds the result register.
// ----------------------------------------------------------------------------
module sas_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sas_pkg::sas_cfg_t   cfg,
  input  sas_pkg::sas_job_t   job,
  input  logic                job_avail,
  output logic                job_pop,
  sas_out_if.source           out_ch
);
  import sas_pkg::*;

  typedef enum logic [26:0] {
    ST_IDLE = 27'd1 << 0,  ST_LX  = 27'd1 << 1,  ST_LY  = 27'd1 << 2,
    ST_LS   = 27'd1 << 3,  ST_MM  = 27'd1 << 4,  ST_MC  = 27'd1 << 5,
    ST_LW   = 27'd1 << 6,  ST_SPM = 27'd1 << 7,  ST_SPD = 27'd1 << 8,
    ST_SPW  = 27'd1 << 9,  ST_SMX = 27'd1 << 10, ST_SDX = 27'd1 << 11,
    ST_SWX  = 27'd1 << 12, ST_SMY = 27'd1 << 13, ST_SDY = 27'd1 << 14,
    ST_SWY  = 27'd1 << 15, ST_CR  = 27'd1 << 16, ST_ARV = 27'd1 << 17,
    ST_ACC  = 27'd1 << 18, ST_CH  = 27'd1 << 19, ST_IVX = 27'd1 << 20,
    ST_IVY  = 27'd1 << 21, ST_IVE = 27'd1 << 22, ST_IPX = 27'd1 << 23,
    ST_IPY  = 27'd1 << 24, ST_IPE = 27'd1 << 25, ST_OUT = 27'd1 << 26
  } state_t;

  // what the shared length/scale steps are serving
  typedef enum logic [4:0] {
    PH_NEIGH  = 5'b00001,
    PH_TARGET = 5'b00010,
    PH_CLAR   = 5'b00100,
    PH_CLAC   = 5'b01000,
    PH_CLV    = 5'b10000
  } phase_t;

  state_t               st_r;
  phase_t               ph_r;
  sas_job_t             j_r;
  logic [CW-1:0]        ux_r, uy_r, sm_r, cm_r;
  logic                 sgx_r, sgy_r, big_r;
  logic [RW-1:0]        len_r;
  logic [SQW-1:0]       sum_r;
  logic [VW-1:0]        cmx_r, cmy_r;
  logic [PW-1:0]        qx_r;
  logic signed [W-1:0]  rx_r, ry_r, arx_r, ary_r, accx_r, accy_r, velx_r, vely_r;
  logic signed [W-1:0]  posx_r, posy_r;
  logic signed [SEPW-1:0] sepx_r, sepy_r;
  logic                 out_valid_r;
  logic signed [W-1:0]  o_px_r, o_py_r, o_vx_r, o_vy_r, o_ax_r, o_ay_r;

  logic [CW-1:0]        mul_a, mul_b;
  logic [PW-1:0]        mul_p_r;
  logic                 sq_start, sq_done, dv_start, dv_done;
  logic [SQW-1:0]       sq_din;
  logic [RW-1:0]        sq_root;
  logic [RW-1:0]        dv_dvs;
  logic [PW-1:0]        dv_quo;
  logic                 is_clamp, fits, out_load;
  logic signed [VW-1:0] arv_dx, arv_dy, arv_x, arv_y, accsum_x, accsum_y;
  logic signed [VW-1:0] step_p, vnew, pnew;
  logic signed [W-1:0]  pclamp;

  function automatic logic [CW-1:0] mag32(input logic signed [W-1:0] v);
    logic [W-1:0] t;
    t = v[W-1] ? W'(-v) : W'(v);
    return t[CW-1:0];
  endfunction

  function automatic logic [VW-1:0] mag42(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  function automatic logic signed [W-1:0] signed_of(input logic neg, input logic [CW-1:0] m);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic signed [SEPW-1:0] sep_add(input logic signed [SEPW-1:0] s,
                                                   input logic neg, input logic [PW-1:0] q);
    logic signed [63:0] t;
    logic signed [63:0] sv;
    sv = $signed({2'b00, q});
    t  = 64'(s) + (neg ? -sv : sv);
    if (t > 64'sd549755813887)       return $signed({1'b0, {(SEPW-1){1'b1}}});
    else if (t < -64'sd549755813888) return $signed({1'b1, {(SEPW-1){1'b0}}});
    else                             return t[SEPW-1:0];
  endfunction

  // shared units
  sas_isqrt u_sqrt (
    .clk, .rst_n, .start(sq_start), .din(sq_din), .done(sq_done), .root(sq_root)
  );

  sas_div u_div (
    .clk, .rst_n, .start(dv_start), .dvd(mul_p_r), .dvs(dv_dvs), .done(dv_done), .quo(dv_quo)
  );

  assign is_clamp = (ph_r == PH_CLAR) || (ph_r == PH_CLAC) || (ph_r == PH_CLV);
  assign fits     = !big_r && (sum_r <= {1'b0, mul_p_r});
  assign sq_start = ((st_r == ST_LS) && !is_clamp) || ((st_r == ST_MC) && !fits);
  assign sq_din   = (st_r == ST_LS) ? sum_r + {1'b0, mul_p_r} : sum_r;
  assign dv_start = (st_r == ST_SPD) || (st_r == ST_SDX) || (st_r == ST_SDY);
  assign dv_dvs   = (st_r == ST_SPD) ? {1'b0, cfg.slow_radius} : len_r;
  assign job_pop  = (st_r == ST_IDLE) && job_avail;
  assign out_load = (st_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // multiplier operand select, product registered
  always_comb begin
    case (st_r)
      ST_LX:   begin mul_a = ux_r;              mul_b = ux_r;                  end
      ST_LY:   begin mul_a = uy_r;              mul_b = uy_r;                  end
      ST_MM:   begin mul_a = cm_r;              mul_b = cm_r;                  end
      ST_SPM:  begin mul_a = cfg.max_speed;     mul_b = len_r[CW-1:0];         end
      ST_SMX:  begin mul_a = ux_r;              mul_b = sm_r;                  end
      ST_SMY:  begin mul_a = uy_r;              mul_b = sm_r;                  end
      ST_IVX:  begin mul_a = mag32(accx_r);     mul_b = CW'(cfg.time_step);    end
      ST_IVY:  begin mul_a = mag32(accy_r);     mul_b = CW'(cfg.time_step);    end
      ST_IPX:  begin mul_a = mag32(velx_r);     mul_b = CW'(cfg.time_step);    end
      ST_IPY:  begin mul_a = mag32(vely_r);     mul_b = CW'(cfg.time_step);    end
      default: begin mul_a = '0;                mul_b = '0;                    end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // arrive force, steering sum and integration terms
  always_comb begin
    arv_dx   = VW'(rx_r) - VW'(j_r.vx);
    arv_dy   = VW'(ry_r) - VW'(j_r.vy);
    arv_x    = (arv_dx <<< GAIN_SH3) + (arv_dx <<< GAIN_SH1);
    arv_y    = (arv_dy <<< GAIN_SH3) + (arv_dy <<< GAIN_SH1);
    accsum_x = VW'(j_r.ax) + VW'(arx_r) + VW'(sepx_r);
    accsum_y = VW'(j_r.ay) + VW'(ary_r) + VW'(sepy_r);
    step_p   = $signed({11'd0, mul_p_r[DT_SH+CW-1:DT_SH]});
    if (st_r == ST_IVY) vnew = accx_r[W-1] ? VW'(j_r.vx) - step_p : VW'(j_r.vx) + step_p;
    else                vnew = accy_r[W-1] ? VW'(j_r.vy) - step_p : VW'(j_r.vy) + step_p;
    if (st_r == ST_IPY) begin
      pnew = velx_r[W-1] ? VW'(j_r.px) - step_p : VW'(j_r.px) + step_p;
      if (pnew > $signed({11'd0, cfg.world_width})) pclamp = $signed({1'b0, cfg.world_width});
      else if (pnew < 0)                            pclamp = '0;
      else                                          pclamp = pnew[W-1:0];
    end else begin
      pnew = vely_r[W-1] ? VW'(j_r.py) - step_p : VW'(j_r.py) + step_p;
      if (pnew > $signed({11'd0, cfg.world_height})) pclamp = $signed({1'b0, cfg.world_height});
      else if (pnew < 0)                             pclamp = '0;
      else                                           pclamp = pnew[W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ph_r        <= PH_NEIGH;
      out_valid_r <= 1'b0;
      sepx_r      <= '0;
      sepy_r      <= '0;
    end else begin
      if (out_load)                          out_valid_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (job_avail) begin
          ph_r <= (job.opcode == OP_UPDATE) ? PH_TARGET : PH_NEIGH;
          st_r <= ST_LX;
        end
        ST_LX:  st_r <= ST_LY;
        ST_LY:  st_r <= ST_LS;
        ST_LS:  st_r <= is_clamp ? ST_MM : ST_LW;
        ST_MM:  st_r <= ST_MC;
        ST_MC:  st_r <= fits ? ST_CR : ST_LW;
        ST_LW: if (sq_done) begin
          case (ph_r)
            PH_NEIGH:
              st_r <= (sq_root != '0 && sq_root < {1'b0, cfg.separate_distance})
                      ? ST_SMX : ST_IDLE;
            PH_TARGET:
              if (sq_root >= {1'b0, cfg.arrive_radius}) begin
                if (cfg.slow_radius != '0 && sq_root <= {1'b0, cfg.slow_radius})
                  st_r <= ST_SPM;
                else
                  st_r <= (sq_root != '0) ? ST_SMX : ST_ARV;
              end else begin
                st_r <= ST_ACC;
              end
            default: st_r <= (sq_root == '0) ? ST_CR : ST_SMX;
          endcase
        end
        ST_SPM: st_r <= ST_SPD;
        ST_SPD: st_r <= ST_SPW;
        ST_SPW: if (dv_done) st_r <= (len_r != '0) ? ST_SMX : ST_ARV;
        ST_SMX: st_r <= ST_SDX;
        ST_SDX: st_r <= ST_SWX;
        ST_SWX: if (dv_done) st_r <= ST_SMY;
        ST_SMY: st_r <= ST_SDY;
        ST_SDY: st_r <= ST_SWY;
        ST_SWY: if (dv_done) begin
          case (ph_r)
            PH_NEIGH: begin
              sepx_r <= sep_add(sepx_r, sgx_r, qx_r);
              sepy_r <= sep_add(sepy_r, sgy_r, dv_quo);
              st_r   <= ST_IDLE;
            end
            PH_TARGET: st_r <= ST_ARV;
            default:   st_r <= ST_CR;
          endcase
        end
        ST_CR: begin
          case (ph_r)
            PH_CLAR: st_r <= ST_ACC;
            PH_CLAC: st_r <= ST_IVX;
            default: st_r <= ST_IPX;
          endcase
        end
        ST_ARV: begin ph_r <= PH_CLAR; st_r <= ST_CH; end
        ST_ACC: begin ph_r <= PH_CLAC; st_r <= ST_CH; end
        ST_CH:  if (cmx_r[VW-1:CW] == '0 && cmy_r[VW-1:CW] == '0) st_r <= ST_LX;
        ST_IVX: st_r <= ST_IVY;
        ST_IVY: st_r <= ST_IVE;
        ST_IVE: begin ph_r <= PH_CLV; st_r <= ST_CH; end
        ST_IPX: st_r <= ST_IPY;
        ST_IPY: st_r <= ST_IPE;
        ST_IPE: st_r <= ST_OUT;
        ST_OUT: if (out_load) begin
          sepx_r      <= '0;
          sepy_r      <= '0;
          st_r        <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: if (job_avail) begin
        j_r   <= job;
        ux_r  <= mag32(job.dx);
        uy_r  <= mag32(job.dy);
        sgx_r <= job.dx[W-1];
        sgy_r <= job.dy[W-1];
        arx_r <= '0;
        ary_r <= '0;
      end
      ST_LY: sum_r <= {1'b0, mul_p_r};
      ST_LS: sum_r <= sum_r + {1'b0, mul_p_r};
      ST_MC: if (fits) begin
        rx_r <= signed_of(sgx_r, ux_r);
        ry_r <= signed_of(sgy_r, uy_r);
      end
      ST_LW: if (sq_done) begin
        len_r <= sq_root;
        case (ph_r)
          PH_NEIGH:  sm_r <= cfg.max_accel;
          PH_TARGET: begin
            sm_r <= cfg.max_speed;
            rx_r <= '0;
            ry_r <= '0;
          end
          default: begin
            sm_r <= cm_r;
            rx_r <= signed_of(sgx_r, ux_r);
            ry_r <= signed_of(sgy_r, uy_r);
          end
        endcase
      end
      ST_SPW: if (dv_done) sm_r <= dv_quo[CW-1:0];
      ST_SWX: if (dv_done) qx_r <= dv_quo;
      ST_SWY: if (dv_done) begin
        rx_r <= signed_of(sgx_r, qx_r[CW-1:0]);
        ry_r <= signed_of(sgy_r, dv_quo[CW-1:0]);
      end
      ST_CR: begin
        case (ph_r)
          PH_CLAR: begin arx_r  <= rx_r; ary_r  <= ry_r; end
          PH_CLAC: begin accx_r <= rx_r; accy_r <= ry_r; end
          default: begin velx_r <= rx_r; vely_r <= ry_r; end
        endcase
      end
      ST_ARV: begin
        cmx_r <= mag42(arv_x);   sgx_r <= arv_x[VW-1];
        cmy_r <= mag42(arv_y);   sgy_r <= arv_y[VW-1];
        cm_r  <= cfg.max_accel;  big_r <= 1'b0;
      end
      ST_ACC: begin
        cmx_r <= mag42(accsum_x); sgx_r <= accsum_x[VW-1];
        cmy_r <= mag42(accsum_y); sgy_r <= accsum_y[VW-1];
        cm_r  <= cfg.max_accel;   big_r <= 1'b0;
      end
      ST_CH: begin
        if (cmx_r[VW-1:CW] != '0 || cmy_r[VW-1:CW] != '0) begin
          cmx_r <= cmx_r >> 1;
          cmy_r <= cmy_r >> 1;
          big_r <= 1'b1;
        end else begin
          ux_r <= cmx_r[CW-1:0];
          uy_r <= cmy_r[CW-1:0];
        end
      end
      ST_IVY: begin cmx_r <= mag42(vnew); sgx_r <= vnew[VW-1]; end
      ST_IVE: begin
        cmy_r <= mag42(vnew);  sgy_r <= vnew[VW-1];
        cm_r  <= cfg.max_speed; big_r <= 1'b0;
      end
      ST_IPY: posx_r <= pclamp;
      ST_IPE: posy_r <= pclamp;
      // result register only changes once the previous result has gone
      ST_OUT: if (out_load) begin
        o_px_r <= posx_r;
        o_py_r <= posy_r;
        o_vx_r <= velx_r;
        o_vy_r <= vely_r;
        o_ax_r <= accx_r;
        o_ay_r <= accy_r;
      end
      default: ;
    endcase
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.new_pos_x = o_px_r;
  assign out_ch.new_pos_y = o_py_r;
  assign out_ch.new_vel_x = o_vx_r;
  assign out_ch.new_vel_y = o_vy_r;
  assign out_ch.new_acc_x = o_ax_r;
  assign out_ch.new_acc_y = o_ay_r;

endmodule

>>> rtl/steering_arrive_separate_step.sv
// ----------------------------------------------------------------------------
// steering_arrive_separate_step: arrive and separation steering update
// Neighbor requests build a separation sum; an update request returns the
// new position, velocity and acceleration of the agent.
// ----------------------------------------------------------------------------
// Requests enter a two-deep queue and are worked one at a time by a sequencer
// that shares one 31x31 multiplier, a square root unit and a restoring
// divider (one quotient bit per cycle). A neighbor request that is out of
// range ends once its length is known; one in range adds to the separation
// sum. An update is shortest short of the arrive radius with no clamping and
// longest with a ramped speed and every magnitude clamp taken; the divider
// does most of that work. The result register holds a finished update while
// the queue keeps taking requests as long as it has room.
module steering_arrive_separate_step (
  input  logic                        clk,
  input  logic                        rst_n,
  sas_in_if.sink                      in_item,
  sas_out_if.source                   out_res,
  input  logic                        cfg_we,
  input  logic [sas_pkg::CFG_AW-1:0]  cfg_idx,
  input  logic [sas_pkg::CW-1:0]      cfg_wdata
);
  import sas_pkg::*;

  sas_cfg_t  cfg_r;
  sas_job_t  front_job, queue_job;
  sas_qctl_t q_ctl;
  sas_qsts_t q_sts;
  logic      push, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_accel         <= RST_MAX_ACCEL;
      cfg_r.max_speed         <= RST_MAX_SPEED;
      cfg_r.time_step         <= RST_TIME_STEP;
      cfg_r.world_width       <= RST_WORLD_WIDTH;
      cfg_r.world_height      <= RST_WORLD_HEIGHT;
      cfg_r.arrive_radius     <= RST_ARRIVE_RAD;
      cfg_r.slow_radius       <= RST_SLOW_RAD;
      cfg_r.separate_distance <= RST_SEP_DIST;
    end else if (cfg_we) begin
      case (sas_reg_t'(cfg_idx))
        REG_MAX_ACCEL:    cfg_r.max_accel         <= cfg_wdata;
        REG_MAX_SPEED:    cfg_r.max_speed         <= cfg_wdata;
        REG_TIME_STEP:    cfg_r.time_step         <= cfg_wdata[TSW-1:0];
        REG_WORLD_WIDTH:  cfg_r.world_width       <= cfg_wdata;
        REG_WORLD_HEIGHT: cfg_r.world_height      <= cfg_wdata;
        REG_ARRIVE_RAD:   cfg_r.arrive_radius     <= cfg_wdata;
        REG_SLOW_RAD:     cfg_r.slow_radius       <= cfg_wdata;
        REG_SEP_DIST:     cfg_r.separate_distance <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign q_ctl.push = push;
  assign q_ctl.pop  = pop;

  sas_front u_front (
    .in_ch(in_item), .q_sts(q_sts), .push(push), .job(front_job)
  );

  sas_fifo u_fifo (
    .clk, .rst_n, .q_ctl(q_ctl), .din(front_job), .q_sts(q_sts), .dout(queue_job)
  );

  sas_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .job(queue_job), .job_avail(q_sts.avail),
    .job_pop(pop), .out_ch(out_res)
  );

endmodule
